/* hw/rtl/max_window_sum_finder_top_assert.svh */
// ----------------------------------------------------------------------------
// max_window_sum_finder_top_assert.svh
// Assertion macros for the window sum finder.
// ----------------------------------------------------------------------------
`ifndef MAX_WINDOW_SUM_FINDER_TOP_ASSERT_SVH
`define MAX_WINDOW_SUM_FINDER_TOP_ASSERT_SVH

// same-cycle implication
`define MWSF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MWSF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/mwsf_pkg.sv */
// ----------------------------------------------------------------------------
// mwsf_pkg
// Types, widths and helpers shared by the window sum finder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mwsf_pkg;

  localparam int MAX_WINDOW = 256;
  localparam int VALUE_W    = 16;
  localparam int WIN_IDX_W  = $clog2(MAX_WINDOW);
  localparam int LEN_W      = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W      = 24;
  localparam int POS_W      = 16;

  typedef struct packed {
    logic [15:0] value;
    logic        last;
  } in_item_t;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic [SUM_W-1:0] best_sum;
    logic             found;
  } out_item_t;

  typedef struct packed {
    logic                 shift_en;
    logic [WIN_IDX_W-1:0] len_m1;
  } chain_ctrl_t;

  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] r);
    logic [LEN_W-1:0] l;
    if (r == '0) begin
      l = LEN_W'(1);
    end else if (r > LEN_W'(MAX_WINDOW)) begin
      l = LEN_W'(MAX_WINDOW);
    end else begin
      l = r;
    end
    return l;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/max_window_sum_finder_top.sv */
// ----------------------------------------------------------------------------
// max_window_sum_finder_top
// Largest fixed-length sliding window sum over a stream, with its start index.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one value per item, in_item.last closes a sequence.
//   out_* : one result per sequence (position, best_sum, found), issued
//           on the cycle after the last item is accepted.
//   cfg_* : window length, written while idle; it is latched at the first
//           item of each sequence (0 acts as 1, above 256 acts as 256).
// Throughput is one item per cycle while no last item is held off: the
// running sum, best compare and the delay line shift all complete in the
// accepting cycle. The last item's result is held in the output register.
// The receiver may stall the result; items that are not last keep flowing,
// and a last item is held off only while an earlier result still waits.
// Reset clears the sequence state, the output valid and sets the window
// length to 1. The delay line is not cleared; it is only read once the
// current sequence has filled it.
// ----------------------------------------------------------------------------
`default_nettype none

module max_window_sum_finder_top (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  mwsf_pkg::in_item_t           in_item,
  output logic                         out_valid,
  input  wire                          out_stall,
  output mwsf_pkg::out_item_t          out_item,
  input  wire                          cfg_we,
  input  wire [mwsf_pkg::LEN_W-1:0]    cfg_wdata
);
  import mwsf_pkg::*;

  logic [LEN_W-1:0] window_len_r;
  logic [LEN_W-1:0] cur_len_r, cur_len_nxt;
  logic [SUM_W-1:0] running_sum_r, running_sum_nxt;
  logic [LEN_W-1:0] fill_count_r, fill_count_nxt;
  logic [SUM_W-1:0] best_total_r, best_total_nxt;
  logic [POS_W-1:0] best_start_r, best_start_nxt;
  logic [POS_W-1:0] item_index_r, item_index_nxt;
  logic             have_window_r, have_window_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_item_r, out_item_nxt;

  logic               accept;
  logic [LEN_W-1:0]   len_dec;
  logic               full_pre;
  logic               full_post;
  logic               take;
  logic [SUM_W-1:0]   sum_new;
  logic [POS_W-1:0]   start_new;
  logic [LEN_W-1:0]   fill_new;
  logic [VALUE_W-1:0] tap_value;
  chain_ctrl_t        chain_ctrl;

  assign in_stall = out_valid_r && out_stall && in_item.last;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    cur_len_nxt = (item_index_r == '0) ? eff_len(window_len_r) : cur_len_r;
    len_dec     = cur_len_nxt - LEN_W'(1);

    chain_ctrl.shift_en = accept;
    chain_ctrl.len_m1   = len_dec[WIN_IDX_W-1:0];

    full_pre  = fill_count_r >= cur_len_nxt;
    fill_new  = full_pre ? fill_count_r : fill_count_r + LEN_W'(1);
    full_post = fill_new >= cur_len_nxt;
    sum_new   = running_sum_r - (full_pre ? SUM_W'(tap_value) : '0) + SUM_W'(in_item.value);
    start_new = item_index_r - POS_W'(len_dec);
    take      = full_post && (!have_window_r || sum_new >= best_total_r);

    running_sum_nxt = sum_new;
    fill_count_nxt  = fill_new;
    best_total_nxt  = take ? sum_new : best_total_r;
    best_start_nxt  = take ? start_new : best_start_r;
    have_window_nxt = have_window_r || take;
    item_index_nxt  = (item_index_r == '1) ? item_index_r : item_index_r + POS_W'(1);

    out_item_nxt.position = best_start_nxt;
    out_item_nxt.best_sum = best_total_nxt;
    out_item_nxt.found    = have_window_nxt;

    out_valid_nxt = out_valid_r && out_stall;
    if (accept && in_item.last) begin
      out_valid_nxt = 1'b1;
    end
  end

  mwsf_chain u_chain (
    .clk       (clk),
    .ctrl      (chain_ctrl),
    .in_value  (in_item.value),
    .tap_value (tap_value)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_len_r  <= LEN_W'(1);
      cur_len_r     <= LEN_W'(1);
      running_sum_r <= '0;
      fill_count_r  <= '0;
      best_total_r  <= '0;
      best_start_r  <= '0;
      item_index_r  <= '0;
      have_window_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        window_len_r <= cfg_wdata;
      end
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        cur_len_r <= cur_len_nxt;
        if (in_item.last) begin
          running_sum_r <= '0;
          fill_count_r  <= '0;
          best_total_r  <= '0;
          best_start_r  <= '0;
          item_index_r  <= '0;
          have_window_r <= 1'b0;
        end else begin
          running_sum_r <= running_sum_nxt;
          fill_count_r  <= fill_count_nxt;
          best_total_r  <= best_total_nxt;
          best_start_r  <= best_start_nxt;
          item_index_r  <= item_index_nxt;
          have_window_r <= have_window_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_item.last) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

`include "max_window_sum_finder_top_assert.svh"

  `MWSF_ASSERT_NOW(a_fill_bound, 1'b1, fill_count_r <= cur_len_r,
                   "fill count exceeds window length")
  `MWSF_ASSERT_NOW(a_no_window_fill, !have_window_r, fill_count_r < cur_len_r,
                   "full window seen but no best recorded")
  `MWSF_ASSERT_NOW(a_no_window_best, !have_window_r,
                   best_total_r == '0 && best_start_r == '0,
                   "best fields set without a window")
  `MWSF_ASSERT_NEXT(a_last_result, accept && in_item.last, out_valid_r,
                    "last item produced no result")

endmodule

`default_nettype wire

/* hw/rtl/mwsf_cell.sv */
// ----------------------------------------------------------------------------
// mwsf_cell
// One stage of the variable-length delay line: load at the insert point,
// otherwise take the neighbor's value.
// ----------------------------------------------------------------------------
`default_nettype none

module mwsf_cell (
  input  wire                          clk,
  input  wire                          shift_en,
  input  wire                          sel,
  input  wire [mwsf_pkg::VALUE_W-1:0]  in_value,
  input  wire [mwsf_pkg::VALUE_W-1:0]  nbr_value,
  output logic [mwsf_pkg::VALUE_W-1:0] value
);
  import mwsf_pkg::*;

  logic [VALUE_W-1:0] val_r;
  logic [VALUE_W-1:0] val_nxt;

  always_comb begin
    val_nxt = sel ? in_value : nbr_value;
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      val_r <= val_nxt;
    end
  end

  assign value = val_r;

endmodule

`default_nettype wire

/* hw/rtl/mwsf_chain.sv */
// ----------------------------------------------------------------------------
// mwsf_chain
// Row of delay cells; new values enter at cell len-1 and drift to cell 0,
// which presents the value that leaves the window.
// ----------------------------------------------------------------------------
`default_nettype none

module mwsf_chain (
  input  wire                          clk,
  input  mwsf_pkg::chain_ctrl_t        ctrl,
  input  wire [mwsf_pkg::VALUE_W-1:0]  in_value,
  output logic [mwsf_pkg::VALUE_W-1:0] tap_value
);
  import mwsf_pkg::*;

  logic [VALUE_W-1:0] cell_val [MAX_WINDOW];

  genvar i;
  generate
    for (i = 0; i < MAX_WINDOW; i++) begin : g_cell
      logic [VALUE_W-1:0] nbr;
      if (i == MAX_WINDOW - 1) begin : g_end
        assign nbr = '0;
      end else begin : g_mid
        assign nbr = cell_val[i+1];
      end
      mwsf_cell u_cell (
        .clk       (clk),
        .shift_en  (ctrl.shift_en),
        .sel       (ctrl.len_m1 == WIN_IDX_W'(i)),
        .in_value  (in_value),
        .nbr_value (nbr),
        .value     (cell_val[i])
      );
    end
  endgenerate

  assign tap_value = cell_val[0];

endmodule

`default_nettype wire
